[rtl/core/smma_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smma_pkg
// Types, codes and sizes shared by the symmetric multiply-accumulate block.
// ----------------------------------------------------------------------------
package smma_pkg;

  localparam int unsigned MAX_ORDER_DEF = 32;
  localparam int unsigned MAX_COLS_DEF  = 32;

  localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
  localparam logic [31:0] BETA_RESET  = 32'h0000_0000;

  typedef enum logic [2:0] {
    CMD_WR_A    = 3'd0,
    CMD_WR_B    = 3'd1,
    CMD_WR_C    = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_RD_C    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_ROWS  = 2'd2,
    REG_COLS  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_DRAIN,
    ST_SCALE,
    ST_FINISH,
    ST_RESP
  } state_t;

  // Dot-product and fixed-point post-processing control, sequencer to datapath.
  typedef struct packed {
    logic clear;    // start a new dot product
    logic mac;      // operand pair valid in registered read data
    logic scale;    // compute alpha*dot and beta*c terms
    logic finish;   // sum, round, saturate
  } dp_ctrl_t;

endpackage : smma_pkg
`default_nettype wire

[rtl/core/smma_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smma_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module smma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : smma_ram
`default_nettype wire

[rtl/core/smma_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smma_datapath
// Multiply-accumulate of A*B, then alpha/beta scaling, rounding, saturation.
// ----------------------------------------------------------------------------
module smma_datapath
  import smma_pkg::*;
#(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF
) (
  input  wire logic        clk,
  input  wire dp_ctrl_t    ctrl,
  input  wire logic [31:0] a_data,
  input  wire logic [31:0] b_data,
  input  wire logic [31:0] c_data,
  input  wire logic [31:0] alpha,
  input  wire logic [31:0] beta,
  output      logic [31:0] result,
  output      logic        sat
);

  localparam int unsigned DW = 64 + $clog2(MAX_ORDER) + 1;
  localparam int unsigned TW = DW + 34;

  logic signed [63:0]   prod;
  logic                 prod_v;
  logic signed [DW-1:0] dot;
  // alpha*dot is split: dot low 32 unsigned, dot high part signed
  logic signed [63:0]   p_lo;
  logic signed [DW-32+32:0] p_hi;
  logic signed [63:0]   p_bc;
  logic signed [TW-1:0] t;
  logic signed [TW-1:0] sh;

  always_ff @(posedge clk) begin
    prod   <= $signed(a_data) * $signed(b_data);
    prod_v <= ctrl.mac;
    if (ctrl.clear) begin
      dot <= '0;
    end else if (prod_v) begin
      dot <= dot + DW'(prod);
    end
    if (ctrl.scale) begin
      p_lo <= $signed({1'b0, dot[31:0]}) * $signed(alpha);
      p_hi <= $signed(dot[DW-1:32]) * $signed(alpha);
      p_bc <= $signed(c_data) * $signed(beta);
    end
  end

  always_comb begin
    t = (TW'(p_hi) <<< 32) + TW'(p_lo) + (TW'(p_bc) <<< 16)
        + TW'(64'sh8000_0000);
    sh = t >>> 32;
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      if (sh > TW'(64'sh7FFF_FFFF)) begin
        result <= 32'h7FFF_FFFF;
        sat    <= 1'b1;
      end else if (sh < -TW'(64'sh8000_0000)) begin
        result <= 32'h8000_0000;
        sat    <= 1'b1;
      end else begin
        result <= sh[31:0];
        sat    <= 1'b0;
      end
    end
  end

endmodule : smma_datapath
`default_nettype wire

[rtl/core/symmetric_matrix_multiply_accumulate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_matrix_multiply_accumulate
// C = alpha*A*B + beta*C over memory-held A (lower triangle), B and C.
// ----------------------------------------------------------------------------
// Write requests: response valid in the cycle after acceptance; one request
//   per cycle unless the response output stalls. Read C: response follows the
//   registered RAM read and read_value register; input stalls while it is pending.
// Compute: per C entry a product step for each k, then drain, scale, finish
//   and write-back; each product step issues one A/B memory read.
// One request is in work at a time; the response register holds until taken.
// Reset clears config, state machine and saturation flag; memory contents
// are undefined until written.
module symmetric_matrix_multiply_accumulate
  import smma_pkg::*;
#(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF,
  parameter int unsigned MAX_COLS  = MAX_COLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [4:0]  row,
  input  wire logic [4:0]  col,
  input  wire logic [31:0] value,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] read_value,
  output      logic        status,
  output      logic        saturated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int unsigned A_DEPTH  = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int unsigned BC_DEPTH = MAX_ORDER * MAX_COLS;
  localparam int unsigned AAW = $clog2(A_DEPTH);
  localparam int unsigned BAW = $clog2(BC_DEPTH);
  localparam int unsigned SW  = 7;

  // ---------------- configuration ----------------
  logic [31:0] alpha, beta;
  logic [5:0]  rows_cfg, cols_cfg;
  logic [1:0]  preg;

  assign pready = 1'b1;
  assign preg   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= ALPHA_RESET;
      beta     <= BETA_RESET;
      rows_cfg <= 6'd32;
      cols_cfg <= 6'd32;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(preg))
        REG_ALPHA: alpha    <= pwdata;
        REG_BETA:  beta     <= pwdata;
        REG_ROWS:  rows_cfg <= pwdata[5:0];
        REG_COLS:  cols_cfg <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(preg))
      REG_ALPHA: prdata = alpha;
      REG_BETA:  prdata = beta;
      REG_ROWS:  prdata = {26'd0, rows_cfg};
      REG_COLS:  prdata = {26'd0, cols_cfg};
      default:   prdata = '0;
    endcase
  end

  // clamped sizes
  logic [SW-1:0] n, m;
  always_comb begin
    if (rows_cfg == 6'd0) n = SW'(1);
    else if (SW'(rows_cfg) > SW'(MAX_ORDER)) n = SW'(MAX_ORDER);
    else n = SW'(rows_cfg);
    if (cols_cfg == 6'd0) m = SW'(1);
    else if (SW'(cols_cfg) > SW'(MAX_COLS)) m = SW'(MAX_COLS);
    else m = SW'(cols_cfg);
  end

  // ---------------- memories ----------------
  logic           a_we, b_we, c_we;
  logic [AAW-1:0] a_waddr, a_raddr;
  logic [BAW-1:0] b_waddr, b_raddr, c_waddr, c_raddr;
  logic [31:0]    c_wdata, a_rdata, b_rdata, c_rdata;

  smma_ram #(.WIDTH(32), .DEPTH(A_DEPTH)) u_a_ram (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(value),
    .raddr(a_raddr), .rdata(a_rdata));
  smma_ram #(.WIDTH(32), .DEPTH(BC_DEPTH)) u_b_ram (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(value),
    .raddr(b_raddr), .rdata(b_rdata));
  smma_ram #(.WIDTH(32), .DEPTH(BC_DEPTH)) u_c_ram (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata));

  // ---------------- sequencer ----------------
  state_t        state, state_next;
  logic [SW-1:0] ci, cj, ck;
  logic [2:0]    cnt;
  logic          rd_pend;
  logic          sat_flag;
  logic [31:0]   dp_result;
  logic          dp_sat;
  dp_ctrl_t      ctrl;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE) || rd_pend || (out_valid && out_stall);

  // request decode
  logic          in_bad;
  logic [SW-1:0] hi_i, lo_i;
  always_comb begin
    hi_i = (row > col) ? SW'(row) : SW'(col);
    lo_i = (row > col) ? SW'(col) : SW'(row);
    unique case (cmd) inside
      CMD_WR_A:                  in_bad = !(SW'(row) < n && SW'(col) < n);
      CMD_WR_B, CMD_WR_C, CMD_RD_C: in_bad = !(SW'(row) < n && SW'(col) < m);
      CMD_COMPUTE:               in_bad = 1'b0;
      default:                   in_bad = 1'b1;
    endcase
  end

  logic [2*SW-1:0] tri_w, tri_r;
  logic [SW-1:0]   ahi, alo;
  assign tri_w = (hi_i * (hi_i + SW'(1))) >> 1;
  assign ahi   = (ci > ck) ? ci : ck;
  assign alo   = (ci > ck) ? ck : ci;
  assign tri_r = (ahi * (ahi + SW'(1))) >> 1;

  logic [BAW-1:0] rc_addr, ij_addr;
  assign rc_addr = BAW'(row) * BAW'(MAX_COLS) + BAW'(col);
  assign ij_addr = BAW'(ci) * BAW'(MAX_COLS) + BAW'(cj);

  always_comb begin
    a_we    = in_acc && cmd == CMD_WR_A && !in_bad;
    b_we    = in_acc && cmd == CMD_WR_B && !in_bad;
    a_waddr = AAW'(tri_w + (2*SW)'(lo_i));
    b_waddr = rc_addr;
    a_raddr = AAW'(tri_r + (2*SW)'(alo));
    b_raddr = BAW'(ck) * BAW'(MAX_COLS) + BAW'(cj);
    c_raddr = (state == ST_IDLE) ? rc_addr : ij_addr;
    if (state == ST_RESP) begin
      c_we    = 1'b1;
      c_waddr = ij_addr;
      c_wdata = dp_result;
    end else begin
      c_we    = in_acc && cmd == CMD_WR_C && !in_bad;
      c_waddr = rc_addr;
      c_wdata = value;
    end
  end

  always_comb begin
    state_next  = state;
    ctrl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_COMPUTE) begin
          state_next = ST_DOT;
          ctrl.clear = 1'b1;
        end
      end
      ST_DOT: begin
        ctrl.mac = 1'b0;
        if (ck == n - SW'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt == 3'd2) state_next = ST_SCALE;
      end
      ST_SCALE:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_RESP;
      ST_RESP: begin
        ctrl.clear = 1'b1;
        if (cj == m - SW'(1) && ci == n - SW'(1)) state_next = ST_IDLE;
        else state_next = ST_DOT;
      end
      default: state_next = ST_IDLE;
    endcase
    ctrl.scale  = (state == ST_SCALE);
    ctrl.finish = (state == ST_FINISH);
  end

  // a response becomes valid: load done or request refused, read data back, or compute done
  logic out_set;
  assign out_set = (state == ST_IDLE && ((in_acc && cmd != CMD_COMPUTE
                   && !(cmd == CMD_RD_C && !in_bad)) || rd_pend))
                   || (state == ST_RESP && state_next == ST_IDLE);

  // operand pair is in RAM output in the cycle after address issue
  logic mac_d;
  always_ff @(posedge clk) begin
    if (rst) mac_d <= 1'b0;
    else     mac_d <= (state == ST_DOT);
  end

  dp_ctrl_t ctrl_dp;
  always_comb begin
    ctrl_dp     = ctrl;
    ctrl_dp.mac = mac_d;
  end

  smma_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk, .ctrl(ctrl_dp), .a_data(a_rdata), .b_data(b_rdata),
    .c_data(c_rdata), .alpha, .beta, .result(dp_result), .sat(dp_sat));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ci <= '0; cj <= '0; ck <= '0; cnt <= '0;
      sat_flag <= 1'b0;
      out_valid <= 1'b0;
      rd_pend  <= 1'b0;
      status   <= 1'b0;
      read_value <= '0;
    end else begin
      state <= state_next;
      if (out_set) out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
      rd_pend <= (state == ST_IDLE) && in_acc && cmd == CMD_RD_C && !in_bad;
      unique case (state)
        ST_IDLE: begin
          ci <= '0; cj <= '0; ck <= '0; cnt <= '0;
          if (in_acc) begin
            status     <= in_bad;
            read_value <= '0;
          end
          if (rd_pend) begin
            read_value <= c_rdata;
          end
        end
        ST_DOT: begin
          ck  <= ck + SW'(1);
          cnt <= '0;
        end
        ST_DRAIN: cnt <= cnt + 3'd1;
        ST_RESP: begin
          if (dp_sat) sat_flag <= 1'b1;
          ck <= '0;
          if (cj == m - SW'(1)) begin
            cj <= '0;
            ci <= ci + SW'(1);
          end else begin
            cj <= cj + SW'(1);
          end
          if (state_next == ST_IDLE) begin
            status     <= 1'b0;
            read_value <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign saturated = sat_flag;

  // ---------------- assertions ----------------
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("request taken while busy");
  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(sat_flag) |-> sat_flag) else $error("saturation flag cleared");
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DOT |-> ck < n) else $error("k index out of range");
  a_cwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_RESP |-> c_we) else $error("missing C write-back");

endmodule : symmetric_matrix_multiply_accumulate
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks symmetric_matrix_multiply_accumulate against a scoreboard model of
// C = alpha*A*B + beta*C. Runs directed corner requests, clamped sizes and
// randomized phases, with random idle cycles on both handshakes.
// ----------------------------------------------------------------------------
module testbench
  import smma_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_MAX  = 32;
  localparam int unsigned A_SIZE = N_MAX * (N_MAX + 1) / 2;
  localparam int unsigned RANDOM_REQUESTS = 1900;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE = 40;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_HALF = 32'h0000_8000;
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] rd;
    logic        st;
    logic        sat;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = CMD_WR_A;
  logic [4:0]  row = '0;
  logic [4:0]  col = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_value;
  logic        status;
  logic        saturated;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  symmetric_matrix_multiply_accumulate dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scoreboard model state
  logic [31:0] a_tri [A_SIZE];
  logic [31:0] b_mat [N_MAX][N_MAX];
  logic [31:0] c_mat [N_MAX][N_MAX];
  logic        sat_sticky = 1'b0;
  logic [31:0] alpha_q = ALPHA_RESET;
  logic [31:0] beta_q  = BETA_RESET;
  logic [5:0]  rows_q  = 6'd32;
  logic [5:0]  cols_q  = 6'd32;

  reply_t pending_replies[$];
  int     mismatches = 0;
  int     replies_seen = 0;
  int     requests_sent = 0;
  int     computes_sent = 0;
  longint cycles = 0;
  bit     in_idle_on = 1'b1;
  bit     out_idle_on = 1'b1;

  function automatic int unsigned order_n();
    return (rows_q == 0) ? 1 : (rows_q > N_MAX) ? N_MAX : rows_q;
  endfunction

  function automatic int unsigned cols_m();
    return (cols_q == 0) ? 1 : (cols_q > N_MAX) ? N_MAX : cols_q;
  endfunction

  function automatic int unsigned tri_index(int unsigned r, int unsigned c);
    int unsigned hi;
    int unsigned lo;
    hi = (r > c) ? r : c;
    lo = (r > c) ? c : r;
    return hi * (hi + 1) / 2 + lo;
  endfunction

  // exact sum, round half up, saturate
  function automatic logic [31:0] updated_c(int unsigned i, int unsigned j, int unsigned n);
    logic signed [127:0] dot;
    logic signed [127:0] av;
    logic signed [127:0] bv;
    logic signed [127:0] acc;
    dot = '0;
    for (int unsigned k = 0; k < n; k++) begin
      av = $signed(a_tri[tri_index(i, k)]);
      bv = $signed(b_mat[k][j]);
      dot = dot + av * bv;
    end
    av = $signed(alpha_q);
    bv = $signed(beta_q);
    acc = $signed(c_mat[i][j]);
    acc = dot * av + ((bv * acc) <<< 16) + (128'sd1 <<< 31);
    acc = acc >>> 32;
    if (acc > 128'sd2147483647) begin
      sat_sticky = 1'b1;
      return Q_MAX;
    end
    if (acc < -128'sd2147483648) begin
      sat_sticky = 1'b1;
      return Q_MIN;
    end
    return acc[31:0];
  endfunction

  function automatic reply_t apply_request(logic [2:0] op, logic [4:0] r, logic [4:0] c,
                                           logic [31:0] v);
    reply_t rep;
    int unsigned n;
    int unsigned m;
    n = order_n();
    m = cols_m();
    rep = '0;
    case (op)
      CMD_WR_A: begin
        if (r < n && c < n) a_tri[tri_index(r, c)] = v;
        else rep.st = 1'b1;
      end
      CMD_WR_B, CMD_WR_C, CMD_RD_C: begin
        if (r < n && c < m) begin
          if (op == CMD_WR_B) b_mat[r][c] = v;
          else if (op == CMD_WR_C) c_mat[r][c] = v;
          else rep.rd = c_mat[r][c];
        end else begin
          rep.st = 1'b1;
        end
      end
      CMD_COMPUTE: begin
        for (int unsigned i = 0; i < n; i++)
          for (int unsigned j = 0; j < m; j++)
            c_mat[i][j] = updated_c(i, j, n);
      end
      default: rep.st = 1'b1;
    endcase
    rep.sat = sat_sticky;
    return rep;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies pending", cycles,
               pending_replies.size());
      $display("[symmetric_matrix_multiply_accumulate] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= out_idle_on && ($urandom_range(99) < 10);
  end

  // reply checker
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply rd=%h st=%b sat=%b",
                                       read_value, status, saturated);
      end else begin
        want = pending_replies.pop_front();
        if (want.rd !== read_value || want.st !== status || want.sat !== saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply %0d: expected rd=%h st=%b sat=%b, got rd=%h st=%b sat=%b",
                     replies_seen, want.rd, want.st, want.sat,
                     read_value, status, saturated);
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge with in_valid still high
  task automatic send_request(logic [2:0] op, logic [4:0] r, logic [4:0] c, logic [31:0] v);
    if (in_idle_on && $urandom_range(99) < 10) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cmd = op;
    row = r;
    col = c;
    value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(apply_request(op, r, c, v));
    requests_sent++;
    if (op == CMD_COMPUTE) computes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_ALPHA: alpha_q = v;
      REG_BETA:  beta_q = v;
      REG_ROWS:  rows_q = v[5:0];
      default:   cols_q = v[5:0];
    endcase
  endtask

  task automatic configure(logic [31:0] al, logic [31:0] be, logic [5:0] rs, logic [5:0] cs);
    drain_replies();
    write_reg(REG_ALPHA, al);
    write_reg(REG_BETA, be);
    write_reg(REG_ROWS, {26'd0, rs});
    write_reg(REG_COLS, {26'd0, cs});
  endtask

  function automatic logic [31:0] random_q();
    case ($urandom_range(3))
      0: return $urandom();
      1: return Q_ONE * ($urandom_range(0, 6) - 3) + $urandom_range(0, 16'hFFFF);
      default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
    endcase
  endfunction

  // writes every A, B and C entry inside the sizes in use
  task automatic fill_matrices();
    int unsigned n;
    int unsigned m;
    n = order_n();
    m = cols_m();
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j <= i; j++)
        if ($urandom_range(1)) send_request(CMD_WR_A, 5'(i), 5'(j), random_q());
        else send_request(CMD_WR_A, 5'(j), 5'(i), random_q());
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j < m; j++) begin
        send_request(CMD_WR_B, 5'(i), 5'(j), random_q());
        send_request(CMD_WR_C, 5'(i), 5'(j), random_q());
      end
  endtask

  task automatic test_directed();
    configure(ALPHA_RESET, BETA_RESET, 6'd2, 6'd2);
    send_request(CMD_WR_A, 0, 0, Q_MAX);
    send_request(CMD_WR_A, 0, 1, Q_MIN);       // upper entry lands on mirror
    send_request(CMD_WR_A, 1, 1, Q_ONE);
    send_request(CMD_WR_B, 0, 0, Q_MAX);
    send_request(CMD_WR_B, 0, 1, 32'h0000_0001);
    send_request(CMD_WR_B, 1, 0, Q_MIN);
    send_request(CMD_WR_B, 1, 1, Q_HALF);
    send_request(CMD_WR_C, 0, 0, Q_MIN);
    send_request(CMD_WR_C, 0, 1, '0);
    send_request(CMD_WR_C, 1, 0, Q_MAX);
    send_request(CMD_WR_C, 1, 1, 32'hFFFF_FFFF);
    send_request(CMD_RD_C, 1, 0, '0);
    send_request(CMD_COMPUTE, 0, 0, '0);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) send_request(CMD_RD_C, 5'(r), 5'(c), '0);
    send_request(CMD_WR_A, 5'd31, 0, Q_ONE);   // beyond size
    send_request(CMD_WR_B, 0, 5'd2, Q_ONE);
    send_request(CMD_RD_C, 5'd2, 5'd31, '0);
    send_request(CMD_RD_C + 3'd1, 0, 0, Q_ONE); // unused command codes
    send_request(CMD_RD_C + 3'd2, 1, 1, '0);
    send_request(CMD_RD_C + 3'd3, 5'd31, 5'd31, 32'hFFFF_FFFF);
    // alpha zero leaves beta*C
    configure('0, Q_HALF, 6'd2, 6'd2);
    send_request(CMD_COMPUTE, 0, 0, '0);
    send_request(CMD_RD_C, 1, 1, '0);
  endtask

  // run one phase: fill, then mixed requests
  task automatic random_phase(int unsigned count);
    int unsigned n;
    int unsigned m;
    int unsigned pick;
    bit          big;
    logic [2:0]  op;
    n = order_n();
    m = cols_m();
    big = (n * n * m > 200);
    fill_matrices();
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 2) begin
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
      end else if (k == count / 2 + 40) begin
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 12) send_request(CMD_WR_A, 5'($urandom_range(n - 1)),
                                  5'($urandom_range(n - 1)), random_q());
      else if (pick < 24) send_request(CMD_WR_B, 5'($urandom_range(n - 1)),
                                       5'($urandom_range(m - 1)), random_q());
      else if (pick < 36) send_request(CMD_WR_C, 5'($urandom_range(n - 1)),
                                       5'($urandom_range(m - 1)), random_q());
      else if (pick < 62) send_request(CMD_RD_C, 5'($urandom_range(n - 1)),
                                       5'($urandom_range(m - 1)), $urandom());
      else if (pick < 70) begin
        if (!big || $urandom_range(19) == 0)
          send_request(CMD_COMPUTE, 5'($urandom()), 5'($urandom()), $urandom());
        else send_request(CMD_RD_C, 0, 0, '0);
      end else if (pick < 90) begin
        // any index; many fall beyond the sizes in use
        op = 3'($urandom_range(CMD_WR_A, CMD_RD_C));
        if (op == CMD_COMPUTE) op = CMD_WR_B;
        send_request(op, 5'($urandom()), 5'($urandom()), $urandom());
      end else begin
        send_request(3'($urandom_range(CMD_RD_C + 1, 7)), 5'($urandom()), 5'($urandom()),
                     $urandom());
      end
    end
  endtask

  task automatic test_clamped_sizes();
    // zero rows acts as one, oversize cols as the maximum, and the reverse
    configure(Q_ONE, Q_ONE, 6'd0, 6'd63);
    random_phase(60);
    configure(Q_HALF, Q_MIN, 6'd63, 6'd0);
    random_phase(40);
    configure(Q_MAX, Q_MAX, 6'd32, 6'd1);
    send_request(CMD_COMPUTE, 0, 0, '0);
    send_request(CMD_RD_C, 5'd31, 0, '0);
  endtask

  task automatic test_random();
    logic [31:0] al;
    logic [31:0] be;
    int phase;
    phase = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      case (phase % 5)
        0: begin al = Q_ONE; be = Q_HALF; end
        1: begin al = Q_MIN; be = Q_MAX; end
        2: begin al = '0; be = $urandom(); end
        3: begin al = $urandom(); be = '0; end
        default: begin al = random_q(); be = random_q(); end
      endcase
      configure(al, be, 6'($urandom_range(1, 5)), 6'($urandom_range(1, 6)));
      random_phase($urandom_range(80, 160));
      if (phase == 2) drain_replies();
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_clamped_sizes();
    test_random();
    drain_replies();
    $display("%0d requests (%0d computes) sent, %0d replies checked, %0d mismatches",
             requests_sent, computes_sent, replies_seen, mismatches);
    $display("covered loads, reads, computes, clamped sizes, out-of-range and unused codes");
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("[symmetric_matrix_multiply_accumulate] OK");
    end else begin
      $display("[symmetric_matrix_multiply_accumulate] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/smma_pkg.sv
rtl/core/smma_ram.sv
rtl/core/smma_datapath.sv
rtl/core/symmetric_matrix_multiply_accumulate.sv
sim/testbench.sv
